// ----- hdl/qfn_pkg.sv -----
// Shared constants, types and the facet orientation table for the quad facet normal block.
// No dependencies; every other file in hdl/ imports this package.
package qfn_pkg;

  // Defaults for the top-level parameters.
  localparam int HEIGHT_BITS_DEF = 16;
  localparam int MAX_LEVEL_DEF   = 15;

  // Fixed field widths.
  localparam int LEVEL_W = 4;
  localparam int OUT_W   = 16;

  // Normalization datapath widths.
  localparam int MAG_BITS = 30;
  localparam int SUM_W    = 2 * MAG_BITS + 2;
  localparam int ROOT_W   = MAG_BITS + 1;
  localparam int Q_BITS   = 15;
  localparam int NUM_W    = MAG_BITS + Q_BITS + 1;
  localparam int DEN_W    = ROOT_W + 1;

  // The constant y term of every unnormalized facet normal.
  localparam int Y_VAL = 1024;

  localparam int LANES = 4;

  // Lane pipeline depth: five vector stages, the root stages, one setup stage and the divider.
  localparam int LANE_LAT = 5 + ROOT_W + 1 + Q_BITS;

  // How a facet maps P and Q onto its x and z components.
  typedef struct packed {
    logic swap;
    logic neg_x;
    logic neg_z;
  } facet_map_t;

  // Magnitudes and signs that travel alongside the square root.
  typedef struct packed {
    logic [2:0][MAG_BITS-1:0] mag;
    logic [2:0]               neg;
  } norm_tag_t;

  // Facet 0 is (-P, -Q), facet 1 is (Q, -P), facet 2 is (P, Q) and facet 3 is (-Q, P).
  function automatic facet_map_t facet_map(input int k);
    facet_map_t m;
    case (k)
      0: begin
        m = '{swap: 1'b0, neg_x: 1'b1, neg_z: 1'b1};
      end
      1: begin
        m = '{swap: 1'b1, neg_x: 1'b0, neg_z: 1'b1};
      end
      2: begin
        m = '{swap: 1'b0, neg_x: 1'b0, neg_z: 1'b0};
      end
      default: begin
        m = '{swap: 1'b1, neg_x: 1'b1, neg_z: 1'b0};
      end
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/qfn_isqrt.sv -----
// Pipelined integer square root that resolves one root bit per stage.
// Depends on qfn_pkg. A norm_tag_t travels alongside each operand.
module qfn_isqrt import qfn_pkg::*; (
  input  logic             clk,
  input  logic [SUM_W-1:0] radicand,
  input  norm_tag_t        tag_in,
  output logic [ROOT_W-1:0] root,
  output norm_tag_t        tag_out
);

  // The last stage has no remainder consumer, so only earlier stages keep one.
  logic [SUM_W-1:0] rem [ROOT_W-1];
  logic [SUM_W-1:0] acc [ROOT_W];
  norm_tag_t        tag [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - j));
    logic [SUM_W-1:0] rem_in;
    logic [SUM_W-1:0] acc_in;
    logic [SUM_W-1:0] trial;
    norm_tag_t        tag_s;

    if (j == 0) begin : g_first
      assign rem_in = radicand;
      assign acc_in = '0;
      assign tag_s  = tag_in;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign acc_in = acc[j-1];
      assign tag_s  = tag[j-1];
    end

    assign trial = acc_in + BIT;

    // One step of the digit-by-digit root.
    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        acc[j] <= (acc_in >> 1) + BIT;
      end else begin
        acc[j] <= acc_in >> 1;
      end
      tag[j] <= tag_s;
    end

    if (j < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (rem_in >= trial) begin
          rem[j] <= rem_in - trial;
        end else begin
          rem[j] <= rem_in;
        end
      end
    end
  end

  assign root    = ROOT_W'(acc[ROOT_W-1]);
  assign tag_out = tag[ROOT_W-1];

endmodule

// ----- hdl/qfn_div.sv -----
// Pipelined restoring divider producing one quotient bit per stage, then the sign.
// Depends on qfn_pkg. The quotient is known to fit in Q_BITS bits.
module qfn_div import qfn_pkg::*; (
  input  logic                    clk,
  input  logic [NUM_W-1:0]        num,
  input  logic [DEN_W-1:0]        den,
  input  logic                    neg,
  output logic signed [OUT_W-1:0] result
);

  logic [NUM_W-1:0]  rem [Q_BITS-1];
  logic [DEN_W-1:0]  dv  [Q_BITS-1];
  logic [Q_BITS-1:0] quo [Q_BITS];
  logic              sgn [Q_BITS];
  logic signed [OUT_W-1:0] mag_out;

  for (genvar i = 0; i < Q_BITS; i++) begin : g_step
    localparam int B = Q_BITS - 1 - i;
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  dv_in;
    logic [Q_BITS-1:0] quo_in;
    logic              sgn_in;
    logic [NUM_W-1:0]  shifted;
    logic              fits;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign dv_in  = den;
      assign quo_in = '0;
      assign sgn_in = neg;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign dv_in  = dv[i-1];
      assign quo_in = quo[i-1];
      assign sgn_in = sgn[i-1];
    end

    assign shifted = NUM_W'(dv_in) << B;
    assign fits    = (rem_in >= shifted);

    // Set this quotient bit when the shifted divisor fits.
    always_ff @(posedge clk) begin
      quo[i] <= quo_in | (Q_BITS'(fits) << B);
      sgn[i] <= sgn_in;
    end

    if (i < Q_BITS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        rem[i] <= fits ? (rem_in - shifted) : rem_in;
        dv[i]  <= dv_in;
      end
    end
  end

  // Apply the component sign; a zero magnitude stays zero.
  assign mag_out = OUT_W'(quo[Q_BITS-1]);
  assign result  = sgn[Q_BITS-1] ? -mag_out : mag_out;

endmodule

// ----- hdl/qfn_lane.sv -----
// One facet lane: builds the unnormalized normal, scales it, takes its length and divides.
// Depends on qfn_pkg, qfn_isqrt and qfn_div.
module qfn_lane import qfn_pkg::*; #(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF
) (
  input  logic                                  clk,
  input  logic signed [HEIGHT_BITS-1:0]         h_cur,
  input  logic signed [HEIGHT_BITS-1:0]         h_nxt,
  input  logic signed [HEIGHT_BITS+1:0]         h_sum,
  input  logic [$clog2(MAX_LEVEL+1)-1:0]        lvl,
  input  facet_map_t                            fmap,
  output logic signed [OUT_W-1:0]               nx,
  output logic signed [OUT_W-1:0]               ny,
  output logic signed [OUT_W-1:0]               nz
);

  localparam int B_W  = HEIGHT_BITS + 4;
  localparam int V_W  = HEIGHT_BITS + 4 + MAX_LEVEL;
  localparam int MW   = V_W - 1;
  localparam int SH_W = $clog2(MW + 1);

  // Stage A: P and Q scaled by the level, arranged for this facet.
  logic signed [B_W-1:0] p_base;
  logic signed [B_W-1:0] q_base;
  logic signed [V_W-1:0] p_full;
  logic signed [V_W-1:0] q_full;
  logic signed [V_W-1:0] vx_sel;
  logic signed [V_W-1:0] vz_sel;
  logic signed [V_W-1:0] va_x;
  logic signed [V_W-1:0] va_z;

  assign p_base = (B_W'(h_nxt) - B_W'(h_cur)) <<< 2;
  assign q_base = (B_W'(h_sum) <<< 1) - ((B_W'(h_cur) + B_W'(h_nxt)) <<< 2);
  assign p_full = V_W'(p_base) <<< lvl;
  assign q_full = V_W'(q_base) <<< lvl;
  assign vx_sel = fmap.swap ? q_full : p_full;
  assign vz_sel = fmap.swap ? p_full : q_full;

  always_ff @(posedge clk) begin
    va_x <= fmap.neg_x ? -vx_sel : vx_sel;
    va_z <= fmap.neg_z ? -vz_sel : vz_sel;
  end

  // Stage B: sign and magnitude, and the shift that brings the largest below 2^MAG_BITS.
  logic [MW-1:0]   mag_x;
  logic [MW-1:0]   mag_z;
  logic [MW-1:0]   mag_or;
  logic [SH_W-1:0] sh_calc;
  logic [MW-1:0]   mb [3];
  logic [2:0]      negb;
  logic [SH_W-1:0] shb;

  assign mag_x  = MW'(va_x[V_W-1] ? -va_x : va_x);
  assign mag_z  = MW'(va_z[V_W-1] ? -va_z : va_z);
  assign mag_or = mag_x | mag_z | MW'(Y_VAL);

  // The bit length of the OR equals that of the largest magnitude.
  always_comb begin
    int len;
    len = 0;
    for (int i = 0; i < MW; i++) begin
      if (mag_or[i]) begin
        len = i + 1;
      end
    end
    sh_calc = (len > MAG_BITS) ? SH_W'(len - MAG_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    mb[0] <= mag_x;
    mb[1] <= MW'(Y_VAL);
    mb[2] <= mag_z;
    negb  <= {va_z[V_W-1], 1'b0, va_x[V_W-1]};
    shb   <= sh_calc;
  end

  // Stage C: truncating shift into the normalization width.
  norm_tag_t tag_c;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tag_c.mag[i] <= MAG_BITS'(mb[i] >> shb);
    end
    tag_c.neg <= negb;
  end

  // Stage D: squares of the three magnitudes.
  logic [2*MAG_BITS-1:0] sq [3];
  norm_tag_t             tag_d;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= (2*MAG_BITS)'(tag_c.mag[i]) * (2*MAG_BITS)'(tag_c.mag[i]);
    end
    tag_d <= tag_c;
  end

  // Stage E: sum of squares.
  logic [SUM_W-1:0] sum_sq;
  norm_tag_t        tag_e;

  always_ff @(posedge clk) begin
    sum_sq <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    tag_e  <= tag_d;
  end

  // Length of the vector.
  logic [ROOT_W-1:0] root;
  norm_tag_t         tag_r;

  qfn_isqrt u_isqrt (
    .clk      (clk),
    .radicand (sum_sq),
    .tag_in   (tag_e),
    .root     (root),
    .tag_out  (tag_r)
  );

  // Stage F: rounded quotient operands, (m * 2^Q_BITS + R) over 2R.
  logic [ROOT_W-1:0] r_fix;
  logic [NUM_W-1:0]  numf [3];
  logic [DEN_W-1:0]  denf;
  logic [2:0]        negf;

  assign r_fix = (root == '0) ? ROOT_W'(1) : root;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      numf[i] <= (NUM_W'(tag_r.mag[i]) << Q_BITS) + NUM_W'(r_fix);
    end
    denf <= {r_fix, 1'b0};
    negf <= tag_r.neg;
  end

  qfn_div u_div_x (.clk(clk), .num(numf[0]), .den(denf), .neg(negf[0]), .result(nx));
  qfn_div u_div_y (.clk(clk), .num(numf[1]), .den(denf), .neg(negf[1]), .result(ny));
  qfn_div u_div_z (.clk(clk), .num(numf[2]), .den(denf), .neg(negf[2]), .result(nz));

endmodule

// ----- hdl/quad_facet_normals_top.sv -----
// Quad facet normals: four unit facet normals (Q1.14) from the Q8.8 corner heights of a terrain
// quad and its subdivision level. The block is fully pipelined: it accepts one transaction in
// every cycle (busy is always low) and presents each result on done, for one cycle only, after
// the input stage, the four lanes and the merge stage. Each lane carries a one-bit-per-stage
// square root (31 stages) and a one-bit-per-stage divider (15 stages).
// Levels above MAX_LEVEL are treated as MAX_LEVEL. Depends on qfn_pkg and qfn_lane.
module quad_facet_normals_top import qfn_pkg::*; #(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [HEIGHT_BITS-1:0] corner_height_0,
  input  logic signed [HEIGHT_BITS-1:0] corner_height_1,
  input  logic signed [HEIGHT_BITS-1:0] corner_height_2,
  input  logic signed [HEIGHT_BITS-1:0] corner_height_3,
  input  logic [LEVEL_W-1:0]            level,
  output logic                          done,
  output logic signed [OUT_W-1:0]       n0_x,
  output logic signed [OUT_W-1:0]       n0_y,
  output logic signed [OUT_W-1:0]       n0_z,
  output logic signed [OUT_W-1:0]       n1_x,
  output logic signed [OUT_W-1:0]       n1_y,
  output logic signed [OUT_W-1:0]       n1_z,
  output logic signed [OUT_W-1:0]       n2_x,
  output logic signed [OUT_W-1:0]       n2_y,
  output logic signed [OUT_W-1:0]       n2_z,
  output logic signed [OUT_W-1:0]       n3_x,
  output logic signed [OUT_W-1:0]       n3_y,
  output logic signed [OUT_W-1:0]       n3_z
);

  localparam int LVL_W = $clog2(MAX_LEVEL + 1);
  localparam int S_W   = HEIGHT_BITS + 2;

  assign busy = 1'b0;

  // Input stage: register heights, their sum and the saturated level.
  logic signed [HEIGHT_BITS-1:0] h_reg [LANES];
  logic signed [S_W-1:0]         sum_reg;
  logic [LVL_W-1:0]              lvl_reg;

  always_ff @(posedge clk) begin
    h_reg[0] <= corner_height_0;
    h_reg[1] <= corner_height_1;
    h_reg[2] <= corner_height_2;
    h_reg[3] <= corner_height_3;
    sum_reg  <= S_W'(corner_height_0) + S_W'(corner_height_1)
              + S_W'(corner_height_2) + S_W'(corner_height_3);
    lvl_reg  <= (32'(level) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : LVL_W'(level);
  end

  // Valid tracking through the lanes.
  logic [LANE_LAT:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LANE_LAT-1:0], start & ~busy};
      done <= vld[LANE_LAT];
    end
  end

  // One lane per facet; facet k uses corner k and the next corner.
  logic signed [OUT_W-1:0] lx [LANES];
  logic signed [OUT_W-1:0] ly [LANES];
  logic signed [OUT_W-1:0] lz [LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    localparam facet_map_t FMAP = facet_map(k);
    qfn_lane #(
      .HEIGHT_BITS (HEIGHT_BITS),
      .MAX_LEVEL   (MAX_LEVEL)
    ) u_lane (
      .clk   (clk),
      .h_cur (h_reg[k]),
      .h_nxt (h_reg[(k + 1) % LANES]),
      .h_sum (sum_reg),
      .lvl   (lvl_reg),
      .fmap  (FMAP),
      .nx    (lx[k]),
      .ny    (ly[k]),
      .nz    (lz[k])
    );
  end

  // Merge stage: gather the four lane results into the output register.
  always_ff @(posedge clk) begin
    n0_x <= lx[0];
    n0_y <= ly[0];
    n0_z <= lz[0];
    n1_x <= lx[1];
    n1_y <= ly[1];
    n1_z <= lz[1];
    n2_x <= lx[2];
    n2_y <= ly[2];
    n2_z <= lz[2];
    n3_x <= lx[3];
    n3_y <= ly[3];
    n3_z <= lz[3];
  end

`ifndef SYNTHESIS
  // A result only appears a fixed latency after an accepted transaction.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LANE_LAT + 2))
    else $error("done without a matching start");

  // The y component of every facet normal is never negative.
  a_y_nonneg: assert property (@(posedge clk) disable iff (rst)
    done |-> (!n0_y[OUT_W-1] && !n1_y[OUT_W-1] && !n2_y[OUT_W-1] && !n3_y[OUT_W-1]))
    else $error("negative y component");

  // The x components of facets 0 and 1 and the z components of facets 2 and 3 stay within one in Q1.14.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (n0_x <= 16384 && n0_x >= -16384 && n1_x <= 16384 && n1_x >= -16384 &&
              n2_z <= 16384 && n2_z >= -16384 && n3_z <= 16384 && n3_z >= -16384))
    else $error("normal component out of range");
`endif

endmodule

// ----- tb/sv/quad_facet_normals_check.sv -----
// Checker for quad_facet_normals_top: predicts the four facet normals of each accepted quad.
// It compares every strobed result with the oldest prediction. Depends on qfn_pkg.
`timescale 1ns / 1ps
module quad_facet_normals_check import qfn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [15:0]      corner_height_0,
  input  logic signed [15:0]      corner_height_1,
  input  logic signed [15:0]      corner_height_2,
  input  logic signed [15:0]      corner_height_3,
  input  logic [LEVEL_W-1:0]      level,
  input  logic                    done,
  input  logic [11:0][OUT_W-1:0]  normals,
  output int                      fail_count,
  output int                      pending_count,
  output int                      quads_checked
);

  typedef logic [11:0][OUT_W-1:0] normal_set_t;

  normal_set_t expected_normals[$];

  // Integer square root, floor, in the usual one-bit-per-step form.
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Normalizes one vector to signed Q1.14 from its sign and magnitude and writes the
  // three components into the result set at the given facet slot.
  function automatic void unit_vector(input longint v[3], input int slot,
                                      inout normal_set_t set);
    longint unsigned mag[3];
    longint unsigned big;
    longint unsigned sum;
    longint unsigned root;
    longint unsigned q;
    int sh;
    big = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > big) big = mag[i];
    end
    while ((big >> sh) >= (64'd1 << MAG_BITS)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      sum += mag[i] * mag[i];
    end
    root = int_sqrt(sum);
    if (root == 0) root = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 15) + root) / (2 * root);
      if (q > 16384) q = 16384;
      set[slot * 3 + i] = (v[i] < 0) ? OUT_W'(-q) : OUT_W'(q);
    end
  endfunction

  // Four facet normals from the corner heights and the subdivision level.
  function automatic normal_set_t facet_normals_predict(input longint h[4], input int lvl);
    normal_set_t set;
    longint hsum;
    longint scale;
    longint p;
    longint q;
    longint hk;
    longint hn;
    longint v[3];
    hsum = h[0] + h[1] + h[2] + h[3];
    if (lvl > MAX_LEVEL_DEF) lvl = MAX_LEVEL_DEF;
    scale = 64'sd1 << lvl;
    for (int k = 0; k < 4; k++) begin
      hk = h[k];
      hn = h[(k + 1) % 4];
      p = 4 * (hn - hk) * scale;
      q = (2 * hsum - 4 * (hk + hn)) * scale;
      v[1] = Y_VAL;
      case (k)
        0: begin
          v[0] = -p; v[2] = -q;
        end
        1: begin
          v[0] = q; v[2] = -p;
        end
        2: begin
          v[0] = p; v[2] = q;
        end
        default: begin
          v[0] = -q; v[2] = p;
        end
      endcase
      unit_vector(v, k, set);
    end
    return set;
  endfunction

  assign pending_count = expected_normals.size();

  // Predict on each accepted transaction; compare each strobed result.
  always @(posedge clk) begin
    longint h[4];
    normal_set_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      quads_checked <= 0;
    end else begin
      if (start && !busy) begin
        h[0] = corner_height_0;
        h[1] = corner_height_1;
        h[2] = corner_height_2;
        h[3] = corner_height_3;
        expected_normals.push_back(facet_normals_predict(h, int'(level)));
      end
      if (done) begin
        if (expected_normals.size() == 0) begin
          $display("%0t: result with no quad outstanding, got %h", $time, normals);
          errs = 1;
        end else begin
          want = expected_normals.pop_front();
          quads_checked <= quads_checked + 1;
          for (int i = 0; i < 12; i++) begin
            if (normals[i] !== want[i]) begin
              $display("%0t: n%0d_%s expected %0d actual %0d", $time, i / 3,
                       (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z",
                       $signed(want[i]), $signed(normals[i]));
              errs++;
            end
          end
        end
      end
      if (errs != 0) begin
        fail_count <= fail_count + errs;
      end
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the quad facet normals testbench: clock, reset, stimulus and the verdict.
// Depends on qfn_pkg, quad_facet_normals_top and quad_facet_normals_check.
`timescale 1ns / 1ps
module tb;
  import qfn_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_QUADS = 1380;
  localparam int CALM_TAIL = 200;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] corner_height_0;
  logic signed [15:0] corner_height_1;
  logic signed [15:0] corner_height_2;
  logic signed [15:0] corner_height_3;
  logic [LEVEL_W-1:0] level;
  logic done;
  logic [11:0][OUT_W-1:0] normals;
  int fail_count;
  int pending_count;
  int quads_checked;
  int idle_count;
  int quads_sent;

  quad_facet_normals_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .corner_height_0(corner_height_0), .corner_height_1(corner_height_1),
    .corner_height_2(corner_height_2), .corner_height_3(corner_height_3),
    .level(level), .done(done),
    .n0_x(normals[0]), .n0_y(normals[1]), .n0_z(normals[2]),
    .n1_x(normals[3]), .n1_y(normals[4]), .n1_z(normals[5]),
    .n2_x(normals[6]), .n2_y(normals[7]), .n2_z(normals[8]),
    .n3_x(normals[9]), .n3_y(normals[10]), .n3_z(normals[11])
  );

  quad_facet_normals_check checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .corner_height_0(corner_height_0), .corner_height_1(corner_height_1),
    .corner_height_2(corner_height_2), .corner_height_3(corner_height_3),
    .level(level), .done(done), .normals(normals),
    .fail_count(fail_count), .pending_count(pending_count),
    .quads_checked(quads_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: ends the run after too many cycles with no transaction and no result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("watchdog expired with %0d quads outstanding", pending_count);
        $display("tb failed");
        $finish;
      end
    end
  end

  // Drives one quad and holds it until the block takes it.
  task automatic send_quad(input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] c, input logic [15:0] d,
                           input logic [3:0] lvl, input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    corner_height_0 <= a;
    corner_height_1 <= b;
    corner_height_2 <= c;
    corner_height_3 <= d;
    level <= lvl;
    @(posedge clk);
    while (busy) @(posedge clk);
    quads_sent++;
  endtask

  initial begin
    logic [15:0] base;
    int spread;
    rst <= 1'b1;
    start <= 1'b0;
    corner_height_0 <= '0;
    corner_height_1 <= '0;
    corner_height_2 <= '0;
    corner_height_3 <= '0;
    level <= '0;
    quads_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: flat quads, height extremes, steep alternations and every level.
    send_quad(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0, 1'b0);
    send_quad(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd15, 1'b0);
    send_quad(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 4'd15, 1'b0);
    send_quad(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'd0, 1'b0);
    send_quad(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 4'd15, 1'b0);
    send_quad(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 4'd0, 1'b0);
    send_quad(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 4'd15, 1'b0);
    send_quad(16'h8000, 16'h0000, 16'h7fff, 16'h0000, 4'd7, 1'b0);
    send_quad(16'h0001, 16'h0000, 16'h0000, 16'h0000, 4'd0, 1'b0);
    for (int l = 0; l < 16; l++)
      send_quad(16'h0100, 16'hff00, 16'h0080, 16'h0000, 4'(l), 1'b0);

    // Random: half full-range heights, half gentle terrain around a base height.
    for (int i = 0; i < RANDOM_QUADS; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_quad(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  4'($urandom_range(0, 15)), i < RANDOM_QUADS - CALM_TAIL);
      end else begin
        base = 16'($urandom);
        spread = 1 << $urandom_range(0, 10);
        send_quad(base + 16'($urandom_range(0, spread)), base + 16'($urandom_range(0, spread)),
                  base + 16'($urandom_range(0, spread)), base + 16'($urandom_range(0, spread)),
                  4'($urandom_range(0, 15)), i < RANDOM_QUADS - CALM_TAIL);
      end
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d quads (directed extremes, all levels, random terrain); %0d checked.",
             quads_sent, quads_checked);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/qfn_pkg.sv
hdl/qfn_isqrt.sv
hdl/qfn_div.sv
hdl/qfn_lane.sv
hdl/quad_facet_normals_top.sv
tb/sv/quad_facet_normals_check.sv
tb/sv/tb.sv
